>>> rtl/ppcc_pkg.sv
// Shared types and constants for the partial permutation cycle counter.
// Used by ppcc_walk and partial_permutation_cycle_count_core; no dependencies.
package ppcc_pkg;

    // Fixed field widths
    localparam int          FIELD_W     = 11;
    localparam int          MAX_BOARD_DEF = 1024;
    localparam logic [10:0] BOARD_RESET = 11'd1024;
    localparam logic [10:0] RESULT_MAX  = 11'd2047;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,   // zero the entry RAM, one row per cycle
        S_LOAD,    // take words into the map
        S_LIST,    // fetch next listed row, or finish
        S_START,   // listed row arrived, read its entry
        S_STEP     // one walk step per cycle
    } state_t;

    // Decoded input word handed to the sequencer
    typedef struct packed {
        logic take;      // word accepted this cycle
        logic last;      // final word of the set
        logic store;     // row and column both in range
        logic off_diag;  // row differs from column
    } load_t;

endpackage

>>> rtl/ppcc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Generic storage used by ppcc_walk; no dependencies.
module ppcc_ram #(
    parameter int   DEPTH = 1025,
    parameter int   WIDTH = 11,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/ppcc_walk.sv
// Sequencer for loading, walking and clearing the row map and walk marks.
// Depends on ppcc_pkg and ppcc_ram.
module ppcc_walk #(
    parameter int MAX_BOARD = ppcc_pkg::MAX_BOARD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ppcc_pkg::load_t             ld,
    input  logic [ppcc_pkg::FIELD_W-1:0] row,
    input  logic [ppcc_pkg::FIELD_W-1:0] col,
    input  logic                        res_free,
    output logic                        in_ready,
    output logic                        res_valid,
    output logic [ppcc_pkg::FIELD_W-1:0] res_data
);

    localparam int FW = ppcc_pkg::FIELD_W;
    localparam int AW = $clog2(MAX_BOARD + 1);   // entry address, marks, counts
    localparam int LW = $clog2(MAX_BOARD);       // list address
    localparam int EW = FW + AW;                 // entry word: {column, mark}

    ppcc_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] tot_reg, tot_next;
    logic [AW-1:0] cyc_reg, cyc_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          fwd_reg, fwd_next;

    // Entry RAM ports
    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic [AW-1:0] ent_raddr;
    logic [EW-1:0] ent_rdata;

    // List RAM ports
    logic          lst_we;
    logic [LW-1:0] lst_waddr;
    logic [FW-1:0] lst_wdata;
    logic [LW-1:0] lst_raddr;
    logic [FW-1:0] lst_rdata;

    // Walk step decode
    logic [AW-1:0] mark_cur;
    logic [FW-1:0] q_col;
    logic [AW-1:0] q_mark;
    logic          hit;
    logic          stop;
    logic          list_done;
    logic          clr_done;
    logic          list_room;
    logic [AW:0]   sum;

    ppcc_ram #(
        .DEPTH (MAX_BOARD + 1),
        .WIDTH (EW)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    ppcc_ram #(
        .DEPTH (MAX_BOARD),
        .WIDTH (FW)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (lst_we),
        .wr_addr (lst_waddr),
        .wr_data (lst_wdata),
        .rd_addr (lst_raddr),
        .rd_data (lst_rdata)
    );

    // Mark of the current walk is its list position plus one; a write to the
    // row just read back is forwarded since the RAM returns the old word
    assign mark_cur  = idx_reg + AW'(1);
    assign q_col     = ent_rdata[EW-1:AW];
    assign q_mark    = fwd_reg ? mark_cur : ent_rdata[AW-1:0];
    assign hit       = (q_mark == mark_cur);
    assign stop      = hit || (q_mark != '0) || (q_col == '0);
    assign list_done = (idx_reg == tot_reg);
    assign clr_done  = (clr_reg == AW'(MAX_BOARD));
    assign list_room = (32'(tot_reg) < MAX_BOARD);
    assign sum       = {1'b0, tot_reg} + {1'b0, cyc_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppcc_pkg::S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ppcc_pkg::S_LOAD;
                end
            end
            ppcc_pkg::S_LOAD:
            begin
                if (ld.take && ld.last)
                begin
                    state_next = ppcc_pkg::S_LIST;
                end
            end
            ppcc_pkg::S_LIST:
            begin
                if (!list_done)
                begin
                    state_next = ppcc_pkg::S_START;
                end
                else if (res_free)
                begin
                    state_next = ppcc_pkg::S_CLEAR;
                end
            end
            ppcc_pkg::S_START:
            begin
                state_next = ppcc_pkg::S_STEP;
            end
            ppcc_pkg::S_STEP:
            begin
                if (stop)
                begin
                    state_next = ppcc_pkg::S_LIST;
                end
            end
            default:
            begin
                state_next = ppcc_pkg::S_CLEAR;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        clr_next  = clr_reg;
        idx_next  = idx_reg;
        tot_next  = tot_reg;
        cyc_next  = cyc_reg;
        cur_next  = cur_reg;
        fwd_next  = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = clr_reg;
        ent_wdata = '0;
        ent_raddr = cur_reg;
        lst_we    = 1'b0;
        lst_waddr = tot_reg[LW-1:0];
        lst_wdata = row;
        lst_raddr = idx_reg[LW-1:0];
        in_ready  = 1'b0;
        res_valid = 1'b0;
        res_data  = (32'(sum) > 32'(ppcc_pkg::RESULT_MAX)) ? ppcc_pkg::RESULT_MAX
                                                           : FW'(sum);
        unique case (state_reg)
            ppcc_pkg::S_CLEAR:
            begin
                ent_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            ppcc_pkg::S_LOAD:
            begin
                in_ready  = 1'b1;
                ent_waddr = AW'(row);
                ent_wdata = {col, AW'(0)};
                if (ld.take && ld.store)
                begin
                    ent_we = 1'b1;
                    if (ld.off_diag && list_room)
                    begin
                        lst_we   = 1'b1;
                        tot_next = tot_reg + AW'(1);
                    end
                end
                if (ld.take && ld.last)
                begin
                    idx_next = '0;
                end
            end
            ppcc_pkg::S_LIST:
            begin
                if (list_done && res_free)
                begin
                    res_valid = 1'b1;
                    clr_next  = '0;
                    tot_next  = '0;
                    cyc_next  = '0;
                end
            end
            ppcc_pkg::S_START:
            begin
                ent_raddr = AW'(lst_rdata);
                cur_next  = AW'(lst_rdata);
            end
            ppcc_pkg::S_STEP:
            begin
                if (stop)
                begin
                    idx_next = idx_reg + AW'(1);
                    if (hit)
                    begin
                        cyc_next = cyc_reg + AW'(1);
                    end
                end
                else
                begin
                    // mark this row, follow its column
                    ent_we    = 1'b1;
                    ent_waddr = cur_reg;
                    ent_wdata = {q_col, mark_cur};
                    ent_raddr = AW'(q_col);
                    cur_next  = AW'(q_col);
                    fwd_next  = (AW'(q_col) == cur_reg);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppcc_pkg::S_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            tot_reg   <= '0;
            cyc_reg   <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            tot_reg   <= tot_next;
            cyc_reg   <= cyc_next;
            fwd_reg   <= fwd_next;
        end
    end

    // Walk position
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

>>> rtl/partial_permutation_cycle_count_core.sv
// Top level of the partial permutation cycle counter: stream ports, size
// register, input range check and result register. Depends on ppcc_pkg, ppcc_walk.
//
// Words carrying (row, column) pairs are taken one per cycle while loading, into a
// row map held in a single entry RAM; the word with tlast set closes the set. The
// block then walks the map from every listed off-diagonal row: it fetches a listed
// row from the list RAM, reads that row's entry, then steps once per row visited.
// One result word, the off-diagonal count plus the closed cycles (saturated at
// 2047), follows. After reset and after each result the entry RAM is cleared,
// rows 0 to MAX_BOARD, during which no input word is taken; configuration writes
// are taken at any time.
module partial_permutation_cycle_count_core #(
    parameter int MAX_BOARD = ppcc_pkg::MAX_BOARD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: board_size
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [10:0] row_index, [21:11] column_index
    input  logic        s_axis_tlast,   // last_entry
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [10:0] move_count
);

    localparam int FW = ppcc_pkg::FIELD_W;

    logic [FW-1:0]   board_reg;
    logic [FW-1:0]   lim;
    logic [FW-1:0]   row;
    logic [FW-1:0]   col;
    logic            row_ok;
    logic            col_ok;
    ppcc_pkg::load_t ld;
    logic            res_free;
    logic            res_valid;
    logic [FW-1:0]   res_data;
    logic            out_valid_reg;
    logic [FW-1:0]   out_data_reg;

    // Board size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg <= ppcc_pkg::BOARD_RESET;
        end
        else if (cfg_wen)
        begin
            board_reg <= cfg_wdata;
        end
    end

    // Range check of the incoming pair; a zero size acts as one
    assign row = s_axis_tdata[10:0];
    assign col = s_axis_tdata[21:11];
    assign lim = (board_reg == '0) ? FW'(1) : board_reg;
    assign row_ok = (row != '0) && (row <= lim) && (32'(row) <= MAX_BOARD);
    assign col_ok = (col != '0) && (col <= lim) && (32'(col) <= MAX_BOARD);

    always_comb
    begin
        ld.take     = s_axis_tvalid && s_axis_tready;
        ld.last     = s_axis_tlast;
        ld.store    = row_ok && col_ok;
        ld.off_diag = (row != col);
    end

    ppcc_walk #(
        .MAX_BOARD (MAX_BOARD)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld),
        .row       (row),
        .col       (col),
        .res_free  (res_free),
        .in_ready  (s_axis_tready),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result register
    assign res_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

`ifndef SYNTHESIS
    // a result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overrun");

    // the clear pass starts right after a result, so input is refused
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !s_axis_tready)
        else $error("input taken right after result");

    // the last word of a set starts the walk, so input stops
    a_walk_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken after last word");
`endif

endmodule
